// ===== hdl/bb_pkg.sv =====
// Shared types and constants of the 3x3 RGB box blur.
package bb_pkg;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 2'd1;

  localparam int ACTIVE_WIDTH_RST  = 800;
  localparam int ACTIVE_HEIGHT_RST = 600;
  localparam int MIN_DIM           = 2;

  localparam int POS_W       = 10;
  localparam int SUM_W       = 12;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  // floor(s / 9) == (s * 7282) >> 16 for every s up to 9 * 255
  localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;
  localparam logic [7:0] ALPHA = 8'hFF;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] b;
  } sum_t;

  typedef struct packed {
    logic             emit;
    logic             normal;
    logic             keep_col1;
    logic             update;
    logic             top_ok;
    logic             mid_ok;
    logic             frame_end;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } ctrl_t;

  typedef struct packed {
    logic             frame_end;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } info_t;

endpackage

// ===== hdl/bb_ctrl.sv =====
// Raster position counters, frame-size registers and the input stage register.
module bb_ctrl import bb_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int WW = CW + 1,
  localparam int RW = $clog2(MAX_HEIGHT + 3)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 accept,
  input  logic                 cmd,
  input  rgb_t                 pix_in,
  input  logic                 a_go,
  output logic [CW-1:0]        rd_addr,
  output logic                 a_valid,
  output ctrl_t                a_ctrl,
  output logic [CW-1:0]        a_addr,
  output rgb_t                 a_pix
);

  localparam int W_RST = (ACTIVE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : ACTIVE_WIDTH_RST;
  localparam int H_RST = (ACTIVE_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : ACTIVE_HEIGHT_RST;

  logic [CW-1:0] in_col;
  logic [RW-1:0] in_row;
  logic [WW-1:0] width;
  logic [RW-1:0] height;

  logic [WW-1:0] width_next;
  logic [RW-1:0] height_next;
  logic [CW-1:0] c;
  logic [WW-1:0] c_inc;
  logic          in_frame;
  logic          ignore;
  logic          left;
  logic          last;
  ctrl_t         ctrl;
  rgb_t          pix;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_data < CFG_W'(MIN_DIM)) begin
      width_next  = WW'(MIN_DIM);
      height_next = RW'(MIN_DIM);
    end else begin
      width_next  = (32'(cfg_data) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_data);
      height_next = (32'(cfg_data) > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : RW'(cfg_data);
    end
  end

  always_comb begin
    c        = (WW'(in_col) >= width) ? '0 : in_col;
    c_inc    = WW'(c) + WW'(1);
    in_frame = in_row < height;
    ignore   = cmd && in_frame;
    left     = (c == '0) && (in_row >= RW'(2));
    last     = left && (in_row == height + RW'(1));
    pix      = in_frame ? pix_in : '0;

    ctrl.normal    = (c != '0) && (in_row != '0);
    ctrl.emit      = left || ctrl.normal;
    ctrl.keep_col1 = left || (c != CW'(1));
    ctrl.update    = !last;
    ctrl.top_ok    = (in_row >= RW'(2)) && (in_row < height + RW'(2));
    ctrl.mid_ok    = (in_row != '0) && (in_row < height + RW'(1));
    ctrl.frame_end = last;
    ctrl.col       = left ? POS_W'(width - WW'(1)) : POS_W'(WW'(c) - WW'(1));
    ctrl.row       = left ? POS_W'(in_row - RW'(2)) : POS_W'(in_row - RW'(1));
  end

  assign rd_addr = c;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      width   <= WW'(W_RST);
      height  <= RW'(H_RST);
      a_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ACTIVE_WIDTH: begin
            width  <= width_next;
            in_col <= '0;
            in_row <= '0;
          end
          REG_ACTIVE_HEIGHT: begin
            height <= height_next;
            in_col <= '0;
            in_row <= '0;
          end
          default: ;
        endcase
      end else if (accept && !ignore) begin
        if (last) begin
          in_col <= '0;
          in_row <= '0;
        end else if (c_inc >= width) begin
          in_col <= '0;
          in_row <= in_row + RW'(1);
        end else begin
          in_col <= CW'(c_inc);
        end
      end
      if (accept) begin
        a_valid <= !ignore;
      end else if (a_go) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_ctrl <= ctrl;
      a_addr <= c;
      a_pix  <= pix;
    end
  end

endmodule

// ===== hdl/bb_linebuf.sv =====
// Two line buffers holding the rows one and two above the incoming row.
module bb_linebuf import bb_pkg::*; #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  rgb_t          wr_pix,
  output rgb_t          up_q,
  output rgb_t          mid_q
);

  rgb_t upper  [DEPTH];
  rgb_t middle [DEPTH];

  // the middle row moves up as the new pixel takes its place
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper[wr_addr]  <= mid_q;
      middle[wr_addr] <= wr_pix;
    end
    if (rd_en) begin
      up_q  <= upper[rd_addr];
      mid_q <= middle[rd_addr];
    end
  end

endmodule

// ===== hdl/bb_window.sv =====
// 3x3 window columns and the per-channel neighbourhood sum stage.
module bb_window import bb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  a_go,
  input  ctrl_t a_ctrl,
  input  rgb_t  a_pix,
  input  rgb_t  up_q,
  input  rgb_t  mid_q,
  input  logic  b_go,
  output logic  b_valid,
  output sum_t  b_sum,
  output info_t b_info
);

  typedef struct packed {
    rgb_t top;
    rgb_t mid;
    rgb_t bot;
  } col_t;

  col_t col1;
  col_t col2;
  col_t new_col;
  sum_t s1;
  sum_t s2;
  sum_t s3;
  sum_t sum;

  function automatic sum_t col_sum(col_t cv);
    sum_t s;
    s.r = SUM_W'(cv.top.r) + SUM_W'(cv.mid.r) + SUM_W'(cv.bot.r);
    s.g = SUM_W'(cv.top.g) + SUM_W'(cv.mid.g) + SUM_W'(cv.bot.g);
    s.b = SUM_W'(cv.top.b) + SUM_W'(cv.mid.b) + SUM_W'(cv.bot.b);
    return s;
  endfunction

  always_comb begin
    new_col.top = a_ctrl.top_ok ? up_q : '0;
    new_col.mid = a_ctrl.mid_ok ? mid_q : '0;
    new_col.bot = a_pix;
    s1 = a_ctrl.keep_col1 ? col_sum(col1) : '0;
    s2 = col_sum(col2);
    s3 = a_ctrl.normal ? col_sum(new_col) : '0;
    sum.r = s1.r + s2.r + s3.r;
    sum.g = s1.g + s2.g + s3.g;
    sum.b = s1.b + s2.b + s3.b;
  end

  always_ff @(posedge clk) begin
    if (a_go && a_ctrl.update) begin
      col1 <= col2;
      col2 <= new_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_go && a_ctrl.emit) begin
      b_valid <= 1'b1;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && a_ctrl.emit) begin
      b_sum            <= sum;
      b_info.frame_end <= a_ctrl.frame_end;
      b_info.col       <= a_ctrl.col;
      b_info.row       <= a_ctrl.row;
    end
  end

endmodule

// ===== hdl/bb_div.sv =====
// Divide-by-nine by reciprocal multiply, RGBA packing and the output register.
module bb_div import bb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  b_go,
  input  sum_t                  b_sum,
  input  info_t                 b_info,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast,
  output logic                  c_free
);

  localparam int PROD_W = SUM_W + RECIP_W;

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_g;
  logic [PROD_W-1:0] prod_b;
  logic [31:0]       word;

  always_comb begin
    prod_r = PROD_W'(b_sum.r) * PROD_W'(RECIP_9);
    prod_g = PROD_W'(b_sum.g) * PROD_W'(RECIP_9);
    prod_b = PROD_W'(b_sum.b) * PROD_W'(RECIP_9);
    word   = {prod_r[RECIP_SHIFT +: 8], prod_g[RECIP_SHIFT +: 8],
              prod_b[RECIP_SHIFT +: 8], ALPHA};
  end

  assign c_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (b_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      m_tdata <= {(OUT_DATA_W - 32 - 2 * POS_W)'(0), b_info.row, b_info.col, word};
      m_tlast <= b_info.frame_end;
    end
  end

endmodule

// ===== hdl/box_blur_3x3_rgb.sv =====
// 3x3 RGB box blur, top level.
// Accepts one raster pixel per clock and returns one blurred RGBA8888 pixel per
// clock while m_tready holds; a result is registered at the output after the
// transaction that completes its neighbourhood, which is the pixel
// active_width+1 positions later in the stream (the pixel centred one row up and
// one column left; the last pixel of each row comes out with the first pixel of
// the row two below it). Out-of-frame neighbours count as zero and every sum is
// divided by nine, truncated. After the last row, send active_width+1 drain
// transactions (tuser = 1) to flush; the final result carries tlast and the next
// frame starts at row 0. A drain sent before the last row is swallowed. Two
// MAX_WIDTH x 24-bit line buffers are read when a pixel is taken and written back
// as the transaction leaves the input register; they need no clearing pass since
// unwritten entries are masked at the frame borders. Writing active_width or
// active_height restarts the frame; write them only while the block is idle.
module box_blur_3x3_rgb import bb_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic                  s_tuser,   // cmd: 0 pixel, 1 drain
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // pixel_word[31:0], out_col[41:32],
                                           // out_row[51:42], zero[55:52]
  output logic                  m_tlast,   // frame_end
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic          accept;
  logic          a_valid;
  logic          a_go;
  ctrl_t         a_ctrl;
  logic [CW-1:0] a_addr;
  logic [CW-1:0] rd_addr;
  rgb_t          a_pix;
  rgb_t          pix_in;
  rgb_t          up_q;
  rgb_t          mid_q;
  logic          b_valid;
  logic          b_go;
  logic          b_free;
  sum_t          b_sum;
  info_t         b_info;
  logic          c_free;

  assign pix_in.r = s_tdata[7:0];
  assign pix_in.g = s_tdata[15:8];
  assign pix_in.b = s_tdata[23:16];

  assign b_go     = b_valid && c_free;
  assign b_free   = !b_valid || c_free;
  assign a_go     = a_valid && (!a_ctrl.emit || b_free);
  assign s_tready = !a_valid || a_go;
  assign accept   = s_tvalid && s_tready;

  bb_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .cmd       (s_tuser),
    .pix_in    (pix_in),
    .a_go      (a_go),
    .rd_addr   (rd_addr),
    .a_valid   (a_valid),
    .a_ctrl    (a_ctrl),
    .a_addr    (a_addr),
    .a_pix     (a_pix)
  );

  bb_linebuf #(
    .DEPTH (MAX_WIDTH)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .wr_en   (a_go && a_ctrl.update),
    .wr_addr (a_addr),
    .wr_pix  (a_pix),
    .up_q    (up_q),
    .mid_q   (mid_q)
  );

  bb_window u_window (
    .clk     (clk),
    .rst     (rst),
    .a_go    (a_go),
    .a_ctrl  (a_ctrl),
    .a_pix   (a_pix),
    .up_q    (up_q),
    .mid_q   (mid_q),
    .b_go    (b_go),
    .b_valid (b_valid),
    .b_sum   (b_sum),
    .b_info  (b_info)
  );

  bb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .b_go     (b_go),
    .b_sum    (b_sum),
    .b_info   (b_info),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .c_free   (c_free)
  );

endmodule

// ===== hdl/bb_check.sv =====
// Port-level assertions for the box blur, bound to the top level.
module bb_check import bb_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast
);

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output transaction changed while stalled");

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:0] == ALPHA)
    else $error("alpha byte not 0xFF");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_DATA_W-1:52] == '0)
    else $error("tdata padding not zero");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // with the output register empty, nothing can back up to the input
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked while output empty");

endmodule

bind box_blur_3x3_rgb bb_check u_check (.*);

// ===== bench/box_blur_3x3_rgb_tb.sv =====
// Self-checking testbench for the 3x3 RGB box blur: directed frames, then random frames.
module box_blur_3x3_rgb_tb;
  import bb_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 4;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int MAX_REPORTS    = 100;
  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_HEIGHT     = 1024;
  localparam int ROW_CNT_W      = 11;
  localparam int SWAP_AT        = 400;
  localparam int CALM_AT        = 800;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [31:0]      word;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             frame_end;
  } blur_res_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_DRAIN} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    rgb_t                 px;
    logic                 chk;
    blur_res_t            want;
  } dir_row_t;

  localparam rgb_t WHITE = '1;
  localparam rgb_t BLACK = '0;
  localparam rgb_t ODD_PX = 24'h123456;
  localparam rgb_t MAGENTA = 24'hFF00FF;
  localparam rgb_t GREEN = 24'h00FF00;
  // every pixel of a 2x2 frame sees the whole frame: 4 * 255 / 9 = 0x71
  localparam logic [31:0] WHITE_2X2 = 32'h717171FF;
  localparam logic [31:0] BLACK_2X2 = 32'h000000FF;
  localparam blur_res_t NO_RES = '0;

  localparam int DIR_ROWS = 23;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{ROW_DRAIN, REG_ACTIVE_WIDTH,  11'd0,    BLACK,   1'b0, NO_RES},
    '{ROW_PIX,   REG_ACTIVE_WIDTH,  11'd0,    MAGENTA, 1'b0, NO_RES},
    '{ROW_CFG,   REG_SPARE_2,       11'd5,    BLACK,   1'b0, NO_RES},
    '{ROW_CFG,   REG_SPARE_3,       11'h7FF,  BLACK,   1'b0, NO_RES},
    '{ROW_PIX,   REG_ACTIVE_WIDTH,  11'd0,    GREEN,   1'b0, NO_RES},
    '{ROW_CFG,   REG_ACTIVE_WIDTH,  11'd1,    BLACK,   1'b0, NO_RES},
    '{ROW_CFG,   REG_ACTIVE_HEIGHT, 11'd0,    BLACK,   1'b0, NO_RES},
    '{ROW_PIX,   REG_ACTIVE_WIDTH,  11'd0,    WHITE,   1'b0, NO_RES},
    '{ROW_DRAIN, REG_ACTIVE_WIDTH,  11'd0,    WHITE,   1'b0, NO_RES},
    '{ROW_PIX,   REG_ACTIVE_WIDTH,  11'd0,    WHITE,   1'b0, NO_RES},
    '{ROW_PIX,   REG_ACTIVE_WIDTH,  11'd0,    WHITE,   1'b0, NO_RES},
    '{ROW_PIX,   REG_ACTIVE_WIDTH,  11'd0,    WHITE,   1'b1, '{WHITE_2X2, 10'd0, 10'd0, 1'b0}},
    '{ROW_DRAIN, REG_ACTIVE_WIDTH,  11'd0,    BLACK,   1'b1, '{WHITE_2X2, 10'd1, 10'd0, 1'b0}},
    '{ROW_PIX,   REG_ACTIVE_WIDTH,  11'd0,    ODD_PX,  1'b1, '{WHITE_2X2, 10'd0, 10'd1, 1'b0}},
    '{ROW_DRAIN, REG_ACTIVE_WIDTH,  11'd0,    BLACK,   1'b1, '{WHITE_2X2, 10'd1, 10'd1, 1'b1}},
    '{ROW_PIX,   REG_ACTIVE_WIDTH,  11'd0,    BLACK,   1'b0, NO_RES},
    '{ROW_PIX,   REG_ACTIVE_WIDTH,  11'd0,    BLACK,   1'b0, NO_RES},
    '{ROW_PIX,   REG_ACTIVE_WIDTH,  11'd0,    BLACK,   1'b0, NO_RES},
    '{ROW_PIX,   REG_ACTIVE_WIDTH,  11'd0,    BLACK,   1'b1, '{BLACK_2X2, 10'd0, 10'd0, 1'b0}},
    '{ROW_DRAIN, REG_ACTIVE_WIDTH,  11'd0,    WHITE,   1'b1, '{BLACK_2X2, 10'd1, 10'd0, 1'b0}},
    '{ROW_DRAIN, REG_ACTIVE_WIDTH,  11'd0,    WHITE,   1'b1, '{BLACK_2X2, 10'd0, 10'd1, 1'b0}},
    '{ROW_DRAIN, REG_ACTIVE_WIDTH,  11'd0,    WHITE,   1'b1, '{BLACK_2X2, 10'd1, 10'd1, 1'b1}},
    '{ROW_DRAIN, REG_ACTIVE_WIDTH,  11'd0,    WHITE,   1'b0, NO_RES}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  // predictor state
  logic [CFG_W-1:0]     cur_width  = CFG_W'(ACTIVE_WIDTH_RST);
  logic [CFG_W-1:0]     cur_height = CFG_W'(ACTIVE_HEIGHT_RST);
  logic [POS_W-1:0]     pos_col = '0;
  logic [ROW_CNT_W-1:0] pos_row = '0;
  rgb_t                 upper_line [MAX_WIDTH];
  rgb_t                 mid_line [MAX_WIDTH];
  rgb_t                 win [9];

  blur_res_t   blur_exp_q [$];
  int unsigned fail_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned src_idle_pct = 38;
  int unsigned snk_idle_pct = 67;

  box_blur_3x3_rgb #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic logic [31:0] blur9(input rgb_t tap [9]);
    int unsigned sr, sg, sb;
    sr = 0;
    sg = 0;
    sb = 0;
    for (int k = 0; k < 9; k++) begin
      sr += tap[k].r;
      sg += tap[k].g;
      sb += tap[k].b;
    end
    return {8'(sr / 9), 8'(sg / 9), 8'(sb / 9), ALPHA};
  endfunction

  // Advances the predictor by one accepted transaction; returns 1 if it yields a pixel.
  function automatic bit blur_step(input logic cmd, input rgb_t px, output blur_res_t res);
    int unsigned w, h, r, c;
    rgb_t pix, top_v, mid_v;
    rgb_t tap [9];
    bit hit;
    w = clamp_dim(cur_width, MAX_WIDTH);
    h = clamp_dim(cur_height, MAX_HEIGHT);
    r = 32'(pos_row);
    c = 32'(pos_col);
    hit = 1'b0;
    res = '0;
    if (c >= w) c = 0;
    if (cmd == CMD_DRAIN && r < h) return 1'b0;
    if (r < h) pix = px;
    else pix = '0;

    // column 0 of row r finishes the last pixel of row r-2
    if (c == 0 && r >= 2) begin
      for (int k = 0; k < 3; k++) begin
        tap[3*k]   = win[3*k+1];
        tap[3*k+1] = win[3*k+2];
        tap[3*k+2] = '0;
      end
      res.word      = blur9(tap);
      res.col       = POS_W'(w - 1);
      res.row       = POS_W'(r - 2);
      res.frame_end = (r - 2 == h - 1);
      hit = 1'b1;
      if (res.frame_end) begin
        pos_col = '0;
        pos_row = '0;
        return 1'b1;
      end
    end

    if (r >= 2 && r - 2 < h) top_v = upper_line[c];
    else top_v = '0;
    if (r >= 1 && r - 1 < h) mid_v = mid_line[c];
    else mid_v = '0;
    upper_line[c] = mid_line[c];
    mid_line[c]   = pix;

    for (int k = 0; k < 3; k++) begin
      win[3*k]   = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = top_v;
    win[5] = mid_v;
    win[8] = pix;

    if (c >= 1 && r >= 1) begin
      tap = win;
      if (c == 1) begin
        tap[0] = '0;
        tap[3] = '0;
        tap[6] = '0;
      end
      res.word      = blur9(tap);
      res.col       = POS_W'(c - 1);
      res.row       = POS_W'(r - 1);
      res.frame_end = 1'b0;
      hit = 1'b1;
    end

    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    pos_col = POS_W'(c);
    pos_row = ROW_CNT_W'(r);
    return hit;
  endfunction

  function automatic rgb_t rand_px();
    rgb_t p;
    p = rgb_t'(24'($urandom));
    case ($urandom_range(7))
      0: p = '0;
      1: p = '1;
      default: ;
    endcase
    return p;
  endfunction

  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
  endfunction

  task automatic send_item(input logic cmd, input rgb_t px, input bit typed_ok,
                           input blur_res_t typed);
    blur_res_t res;
    cfg_valid <= 1'b0;
    if (items_sent < SWAP_AT) begin
      src_idle_pct = 38;
      snk_idle_pct = 67;
    end else if (items_sent < CALM_AT) begin
      src_idle_pct = 67;
      snk_idle_pct = 38;
    end else begin
      src_idle_pct = 0;
      snk_idle_pct = 0;
    end
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {px.b, px.g, px.r};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (blur_step(cmd, px, res) || typed_ok)
      blur_exp_q.push_back(typed_ok ? typed : res);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ACTIVE_WIDTH: begin
        cur_width = val;
        pos_col = '0;
        pos_row = '0;
      end
      REG_ACTIVE_HEIGHT: begin
        cur_height = val;
        pos_col = '0;
        pos_row = '0;
      end
      default: ;
    endcase
  endtask

  // Waits until every expected pixel is out and the pipeline has emptied.
  task automatic settle();
    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (blur_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One frame with stray drains inside; optionally cut short before the flush.
  task automatic stream_frame(input int unsigned w, input int unsigned h, input bit may_cut,
                              output bit cut, inout int unsigned n);
    int unsigned len, stop;
    len = w * h;
    stop = len;
    cut = 1'b0;
    if (may_cut && $urandom_range(5) == 0) begin
      stop = $urandom_range(len - 1);
      cut = 1'b1;
    end
    for (int unsigned p = 0; p < stop; p++) begin
      if ($urandom_range(19) == 0) send_item(CMD_DRAIN, rand_px(), 1'b0, NO_RES);
      send_item(CMD_PIXEL, rand_px(), 1'b0, NO_RES);
    end
    n += stop;
    if (!cut) begin
      // pixels past the last row act as drains
      for (int unsigned d = 0; d <= w; d++)
        send_item($urandom_range(3) == 0 ? CMD_PIXEL : CMD_DRAIN, rand_px(), 1'b0, NO_RES);
      n += w + 1;
    end
  endtask

  task automatic random_batch(input int unsigned target);
    int unsigned n, w, h, frames;
    logic [CFG_W-1:0] wv, hv;
    bit cut;
    n = 0;
    while (n < target) begin
      case ($urandom_range(9))
        0: wv = CFG_W'($urandom_range(1));
        1: wv = CFG_W'($urandom_range(24, 10));
        default: wv = CFG_W'($urandom_range(8, 2));
      endcase
      if ($urandom_range(7) == 0) hv = CFG_W'($urandom_range(1));
      else hv = CFG_W'($urandom_range(6, 2));
      settle();
      if ($urandom_range(4) == 0)
        write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, CFG_W'($urandom));
      if ($urandom_range(1)) begin
        write_reg(REG_ACTIVE_WIDTH, wv);
        write_reg(REG_ACTIVE_HEIGHT, hv);
      end else begin
        write_reg(REG_ACTIVE_HEIGHT, hv);
        write_reg(REG_ACTIVE_WIDTH, wv);
      end
      w = clamp_dim(wv, MAX_WIDTH);
      h = clamp_dim(hv, MAX_HEIGHT);
      frames = $urandom_range(3, 1);
      for (int unsigned f = 0; f < frames; f++) begin
        stream_frame(w, h, 1'b1, cut, n);
        if (cut) break;
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    blur_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (blur_exp_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("%0t: unexpected pixel: expected none, got %h last %b",
                   $time, m_tdata, m_tlast);
      end else begin
        want = blur_exp_q.pop_front();
        if (m_tdata[31:0] !== want.word) flag_mismatch("pixel_word", want.word, m_tdata[31:0]);
        if (m_tdata[41:32] !== want.col)
          flag_mismatch("out_col", 32'(want.col), 32'(m_tdata[41:32]));
        if (m_tdata[51:42] !== want.row)
          flag_mismatch("out_row", 32'(want.row), 32'(m_tdata[51:42]));
        if (m_tlast !== want.frame_end)
          flag_mismatch("frame_end", 32'(want.frame_end), 32'(m_tlast));
      end
    end
    m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  initial begin : main
    bit prev_cfg;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      mid_line[i]   = '0;
    end
    foreach (win[i]) win[i] = '0;
    prev_cfg = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TAB[i].kind == ROW_CFG) begin
        if (!prev_cfg) settle();
        write_reg(DIR_TAB[i].idx, DIR_TAB[i].val);
      end else begin
        send_item(DIR_TAB[i].kind == ROW_DRAIN ? CMD_DRAIN : CMD_PIXEL, DIR_TAB[i].px,
                  DIR_TAB[i].chk, DIR_TAB[i].want);
      end
      prev_cfg = (DIR_TAB[i].kind == ROW_CFG);
    end

    random_batch(100);
    // widest and tallest frame through the clamp: one full row and the start of the next
    settle();
    write_reg(REG_ACTIVE_WIDTH, '1);
    write_reg(REG_ACTIVE_HEIGHT, '1);
    for (int p = 0; p < MAX_WIDTH + 3; p++) send_item(CMD_PIXEL, rand_px(), 1'b0, NO_RES);
    random_batch(50);
    settle();

    if (fail_cnt == 0) begin
      $display("box_blur_3x3_rgb_tb passed");
    end else begin
      $display("box_blur_3x3_rgb_tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("box_blur_3x3_rgb_tb failed");
    $finish;
  end

endmodule
